// ===== src/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Types, command codes and helpers shared by the subtitle cue tracker.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int CMD_W       = 3;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 80;
  localparam int CUE_W       = 31;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

  localparam logic CFG_ENABLED = 1'b0;
  localparam logic CFG_DELAY   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHK,
    S_CHKRD,
    S_UPD,
    S_NXRD,
    S_SRCH,
    S_EMIT
  } state_t;

  // where the cached pointer stands; an index equal to the cue count is past-end
  typedef enum logic [1:0] {
    PTR_NONE,
    PTR_BEFORE,
    PTR_IDX
  } ptr_kind_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] sum;
    logic signed [31:0] res;
    sum = {a[31], a} + {b[31], b};
    if (sum[32] != sum[31]) begin
      res = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      res = sum[31:0];
    end
    return res;
  endfunction

endpackage

// ===== src/subtitle_cue_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// subtitle_cue_tracker_unit
// Cue interval table with cursor tracking and cached display window.
// ----------------------------------------------------------------------------
// Cue starts and ends live in one RAM with a single port and a registered read.
// Each input transfer gives exactly one result transfer. Clear, append, unused
// commands and commands that need no lookup pass from idle through execute and
// emit to the result register; a set-time check passes through check and may read
// one cue, trying the next cue passes through update and next-read, and a full
// lookup walks the table from the first cue at one entry per cycle through the RAM port. The next
// item is taken as soon as the sequencer is back in idle, even while the last
// result still waits on m_tready. Cue storage needs no clearing after reset.
// ----------------------------------------------------------------------------
module subtitle_cue_tracker_unit #(
  parameter int MAX_CUES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  // cue_start[30:0], cue_end[61:31], time_value[93:62], elapsed_ms[109:94]
  input  logic [sct_pkg::IN_TDATA_W-1:0]    s_tdata,
  // command[2:0]
  input  logic [sct_pkg::CMD_W-1:0]         s_tuser,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // showing[0], shown_index[8:1], text_changed[9], timer_running[10],
  // window_start[42:11], window_end[74:43], append_dropped[75]
  output logic [sct_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [31:0]                       cfg_data
);
  import sct_pkg::*;

  localparam int AW    = $clog2(MAX_CUES);
  localparam int CNT_W = $clog2(MAX_CUES + 1);
  localparam int RAM_W = 2 * CUE_W;

  state_t state, state_next;

  // configuration
  logic               enabled;
  logic signed [31:0] delay_ms;

  // captured item
  logic [CMD_W-1:0]   cmd;
  logic [CUE_W-1:0]   in_start;
  logic [CUE_W-1:0]   in_end;
  logic signed [31:0] in_time;
  logic [15:0]        in_elapsed;

  // tracking state
  logic [CNT_W-1:0]   count;
  ptr_kind_t          ptr_kind;
  logic [CNT_W-1:0]   ptr_idx;
  logic signed [31:0] wlo;
  logic signed [31:0] whi;
  logic signed [31:0] cursor;
  logic signed [31:0] cur_time;
  logic               shown_valid;
  logic [AW-1:0]      shown_cue;
  logic               ticking;
  logic               changed;
  logic               dropped;
  logic [AW-1:0]      srch_idx;

  // ram
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [RAM_W-1:0]   ram_rdata;

  // decisions
  logic               accept;
  logic               out_free;
  logic               in_win;
  logic               at_end;
  logic [CNT_W:0]     p1;
  logic               p1_lt_n;
  logic signed [31:0] rd_s;
  logic signed [31:0] rd_e;
  logic               c_lt_s;
  logic               c_le_e;
  logic               srch_last;
  logic               goto_chk;
  logic               goto_upd;
  logic               cnt_full;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   srch_ext;
  logic [AW+7:0]      shown_ext;
  logic [OUT_TDATA_W-1:0] out_next;

  sct_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_CUES)
  ) u_cue_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_end, in_start}),
    .rdata (ram_rdata)
  );

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  assign in_win    = (cursor >= wlo) && (cursor <= whi);
  assign at_end    = (ptr_kind == PTR_IDX) && (ptr_idx == count);
  assign p1        = {1'b0, ptr_idx} + 1'b1;
  assign p1_lt_n   = p1 < {1'b0, count};
  assign rd_s      = {1'b0, ram_rdata[CUE_W-1:0]};
  assign rd_e      = {1'b0, ram_rdata[RAM_W-1:CUE_W]};
  assign c_lt_s    = cursor < rd_s;
  assign c_le_e    = cursor <= rd_e;
  assign srch_ext  = CNT_W'(srch_idx);
  assign srch_last = (srch_ext + 1'b1) == count;
  assign cnt_full  = count >= CNT_W'(MAX_CUES);
  assign cnt_m1    = count - 1'b1;
  assign goto_chk  = (cmd == CMD_SET) && (in_time != cur_time) && enabled && (count != '0);
  assign goto_upd  = ((cmd == CMD_FINISH) && enabled && (count != '0)) ||
                     ((cmd == CMD_TICK) && ticking && enabled);

  assign shown_ext = {8'b0, shown_cue};
  assign out_next  = {4'b0, dropped, whi, wlo, ticking, changed,
                      (shown_valid ? shown_ext[7:0] : 8'b0), shown_valid};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (goto_chk) state_next = S_CHK;
        else if (goto_upd) state_next = S_UPD;
        else state_next = S_EMIT;
      end
      S_CHK: begin
        if (ptr_kind != PTR_IDX) state_next = S_UPD;
        else if (at_end) state_next = S_CHKRD;
        else if (in_win) state_next = S_EMIT;
        else if (cursor < wlo) state_next = S_UPD;
        else if (p1_lt_n) state_next = S_CHKRD;
        else state_next = S_UPD;
      end
      S_CHKRD: begin
        if (at_end && !c_le_e) state_next = S_EMIT;
        else state_next = S_UPD;
      end
      S_UPD: begin
        if ((count == '0) || at_end || in_win) state_next = S_EMIT;
        else if (ptr_kind == PTR_IDX) state_next = p1_lt_n ? S_NXRD : S_EMIT;
        else state_next = S_SRCH;
      end
      S_NXRD: state_next = S_EMIT;
      S_SRCH: begin
        if (c_lt_s || c_le_e || srch_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    ram_we   = 1'b0;
    ram_addr = '0;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_EXEC: begin
        ram_we   = (cmd == CMD_APPEND) && !cnt_full;
        ram_addr = count[AW-1:0];
      end
      S_CHK:  ram_addr = at_end ? cnt_m1[AW-1:0] : p1[AW-1:0];
      S_UPD:  ram_addr = (ptr_kind == PTR_IDX) ? p1[AW-1:0] : '0;
      S_SRCH: ram_addr = srch_idx + 1'b1;
      default: ram_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled  <= 1'b1;
      delay_ms <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLED: enabled  <= cfg_data[0];
        CFG_DELAY:   delay_ms <= cfg_data;
        default:     ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= s_tuser;
      in_start   <= s_tdata[30:0];
      in_end     <= s_tdata[61:31];
      in_time    <= s_tdata[93:62];
      in_elapsed <= s_tdata[109:94];
    end
  end

  // tracking datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      ptr_kind    <= PTR_NONE;
      ptr_idx     <= '0;
      wlo         <= -32'sd1;
      whi         <= -32'sd1;
      cursor      <= -32'sd1;
      cur_time    <= -32'sd1;
      shown_valid <= 1'b0;
      shown_cue   <= '0;
      ticking     <= 1'b0;
      changed     <= 1'b0;
      dropped     <= 1'b0;
      srch_idx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            changed <= 1'b0;
            dropped <= 1'b0;
          end
        end
        S_EXEC: begin
          case (cmd)
            CMD_CLEAR: begin
              count <= '0;
              if (ptr_kind != PTR_NONE) begin
                ptr_kind    <= PTR_NONE;
                wlo         <= -32'sd1;
                whi         <= -32'sd1;
                shown_valid <= 1'b0;
                ticking     <= 1'b0;
                changed     <= 1'b1;
              end
            end
            CMD_APPEND: begin
              if (cnt_full) dropped <= 1'b1;
              else count <= count + 1'b1;
            end
            CMD_SET: begin
              if (in_time != cur_time) begin
                cur_time <= in_time;
                cursor   <= sat_add(in_time, delay_ms);
              end
            end
            CMD_TICK: begin
              if (ticking) begin
                cursor   <= sat_add(cursor, {16'b0, in_elapsed});
                cur_time <= sat_add(cur_time, {16'b0, in_elapsed});
              end
            end
            default: ;
          endcase
        end
        S_CHK: begin
          if (ptr_kind == PTR_IDX && !at_end && !in_win) begin
            if ((cursor < wlo) || !p1_lt_n) ptr_kind <= PTR_NONE;
          end
        end
        S_CHKRD: begin
          // past-end holds only while the cursor stays beyond the last cue
          if (at_end ? c_le_e : !c_le_e) ptr_kind <= PTR_NONE;
        end
        S_UPD: begin
          srch_idx <= '0;
          if ((count != '0) && !at_end && !in_win && (ptr_kind == PTR_IDX) && !p1_lt_n &&
              shown_valid) begin
            shown_valid <= 1'b0;
            ticking     <= 1'b0;
            changed     <= 1'b1;
          end
        end
        S_NXRD: begin
          if (!c_lt_s && c_le_e) begin
            ptr_idx <= p1[CNT_W-1:0];
            wlo     <= rd_s;
            whi     <= rd_e;
            if (!(shown_valid && shown_cue == p1[AW-1:0])) begin
              shown_valid <= 1'b1;
              shown_cue   <= p1[AW-1:0];
              ticking     <= 1'b1;
              changed     <= 1'b1;
            end
          end else if (shown_valid) begin
            whi         <= rd_s;
            shown_valid <= 1'b0;
            ticking     <= 1'b0;
            changed     <= 1'b1;
          end
        end
        S_SRCH: begin
          srch_idx <= srch_idx + 1'b1;
          if (c_lt_s) begin
            // gap before the cue just read
            ptr_kind    <= PTR_BEFORE;
            wlo         <= '0;
            whi         <= rd_s;
            shown_valid <= 1'b0;
            ticking     <= 1'b0;
            changed     <= 1'b1;
          end else if (c_le_e) begin
            ptr_kind <= PTR_IDX;
            ptr_idx  <= srch_ext;
            wlo      <= rd_s;
            whi      <= rd_e;
            if (!(shown_valid && shown_cue == srch_idx)) begin
              shown_valid <= 1'b1;
              shown_cue   <= srch_idx;
              ticking     <= 1'b1;
              changed     <= 1'b1;
            end
          end else if (srch_last) begin
            ptr_kind <= PTR_IDX;
            ptr_idx  <= count;
            if (shown_valid) begin
              shown_valid <= 1'b0;
              ticking     <= 1'b0;
              changed     <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      m_tdata <= out_next;
    end
  end

  // timer runs exactly while a cue is on display
  a_tick_show: assert property (@(posedge clk) disable iff (rst) ticking == shown_valid)
    else $error("timer state and display state disagree");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CUES))
    else $error("cue count beyond table size");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (ptr_kind == PTR_IDX) |-> (ptr_idx <= count))
    else $error("cue pointer beyond cue count");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second transfer taken while an item is in work");

endmodule

// ===== src/sct_ram.sv =====
// ----------------------------------------------------------------------------
// sct_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sct_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
